// ===== sv/tsm_pkg.sv =====
`timescale 1ns / 1ps
package tsm_pkg;

	// internal fixed point: Q.30
	localparam int IQ           = 30;
	localparam int IN_W         = 24;
	localparam int SUM_W        = IN_W + 1;
	localparam int PROD_W       = SUM_W + IN_W;
	localparam int X_W          = 35;
	localparam int IP_W         = 5;
	localparam int E_W          = IQ + 1;
	localparam int ACC_W        = IQ + 3;
	localparam int RECIP_W      = 33;
	localparam int TAYLOR_TERMS = 16;
	localparam int EXP_FLUSH    = 32;
	// the power chain and the divider both take 31 stages, which keeps them aligned
	localparam int POW_STAGES   = EXP_FLUSH - 1;
	localparam int DIV_STAGES   = IQ + 1;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = 2;

	localparam logic [E_W-1:0] IONE = E_W'(64'd1 << IQ);
	// exp(-1) in Q.30 from the same truncated series
	localparam logic [E_W-1:0] E1   = E_W'(395007543);

	// one classified item waiting between front and back
	typedef struct packed {
		logic [IN_W-1:0]  r10;
		logic [SUM_W-1:0] s;
		logic [IP_W-1:0]  ip;
		logic [IQ-1:0]    frac;
		logic             flush;
		logic             deg;
	} q_entry_t;

	// series state of one item
	typedef struct packed {
		logic [E_W-1:0]   term;
		logic [IQ-1:0]    r;
		logic [ACC_W-1:0] pos;
		logic [ACC_W-1:0] neg;
	} tay_t;

	// values that ride along with the series
	typedef struct packed {
		logic [IN_W-1:0]  r10;
		logic [SUM_W-1:0] s;
		logic [IP_W-1:0]  ip;
		logic             flush;
		logic             deg;
	} side_t;

endpackage

// ===== sv/tsm_front.sv =====
`timescale 1ns / 1ps
module tsm_front import tsm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [3*IN_W-1:0]     s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output q_entry_t              entry
);

	localparam int SHR = (2 * FRAC_BITS > IQ) ? 2 * FRAC_BITS - IQ : 0;
	localparam int SHL = (2 * FRAC_BITS > IQ) ? 0 : IQ - 2 * FRAC_BITS;

	logic [IN_W-1:0]   t;
	logic [IN_W-1:0]   r01;
	logic [IN_W-1:0]   r10;
	logic [SUM_W-1:0]  s;
	logic [PROD_W-1:0] prod;
	logic [63:0]       x_wide;
	logic [X_W-1:0]    x;

	// handshake: accept whenever the queue has room
	assign s_tready = ~q_full;
	assign push     = s_tvalid & ~q_full;

	// total rate, exponent and its split into integer and fraction
	always_comb begin
		t      = s_tdata[IN_W-1:0];
		r01    = s_tdata[2*IN_W-1:IN_W];
		r10    = s_tdata[3*IN_W-1:2*IN_W];
		s      = SUM_W'(r01) + SUM_W'(r10);
		prod   = PROD_W'(s) * PROD_W'(t);
		x_wide = (64'(prod) >> SHR) << SHL;
		x      = X_W'(x_wide);
		entry.r10   = r10;
		entry.s     = s;
		entry.ip    = x[X_W-1:IQ];
		entry.frac  = x[IQ-1:0];
		entry.flush = (prod >> (2 * FRAC_BITS)) >= PROD_W'(EXP_FLUSH);
		entry.deg   = (s == '0);
	end

endmodule

// ===== sv/tsm_queue.sv =====
`timescale 1ns / 1ps
module tsm_queue import tsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	input  logic     pop,
	output q_entry_t dout,
	output logic     full,
	output logic     empty
);

	q_entry_t          mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== sv/tsm_div.sv =====
`timescale 1ns / 1ps
module tsm_div import tsm_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [IN_W-1:0]  r10,
	input  logic [SUM_W-1:0] s,
	output logic [E_W-1:0]   pi0
);

	logic [SUM_W-1:0] rem_q [0:DIV_STAGES-1];
	logic [E_W-1:0]   quo_q [0:DIV_STAGES-1];
	logic [SUM_W-1:0] dv_q  [0:DIV_STAGES-1];

	// restoring division of r10 << 30 by s, one quotient bit a stage
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [SUM_W:0]   trial;
		logic [E_W-1:0]   quo_in;
		logic [SUM_W-1:0] sv;
		logic             ge;
		if (j == 0) begin : g_first
			assign trial  = (SUM_W+1)'(r10);
			assign quo_in = '0;
			assign sv     = s;
		end else begin : g_next
			assign trial  = {rem_q[j-1], 1'b0};
			assign quo_in = quo_q[j-1];
			assign sv     = dv_q[j-1];
		end
		assign ge = trial >= (SUM_W+1)'(sv);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? SUM_W'(trial - (SUM_W+1)'(sv)) : SUM_W'(trial);
				quo_q[j] <= {quo_in[E_W-2:0], ge};
				dv_q[j]  <= sv;
			end
		end
	end

	assign pi0 = quo_q[DIV_STAGES-1];

endmodule

// ===== sv/tsm_back.sv =====
`timescale 1ns / 1ps
module tsm_back import tsm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  q_entry_t             head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FRAC_BITS:0]   p00,
	output logic [FRAC_BITS:0]   p01,
	output logic [FRAC_BITS:0]   p10,
	output logic [FRAC_BITS:0]   p11,
	output logic                 deg
);

	localparam int TT = TAYLOR_TERMS;
	localparam int PS = POW_STAGES;
	localparam int SH = IQ - FRAC_BITS;
	localparam logic [32:0]      RND = 33'(64'd1 << (SH - 1));
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);

	logic en;

	// series stages
	tay_t           tin_w  [1:TT];
	side_t          sin_w  [1:TT];
	logic           vin_w  [1:TT];
	logic [E_W-1:0] a_v_q  [1:TT];
	tay_t           a_t_q  [1:TT];
	side_t          a_s_q  [1:TT];
	logic           a_vld_q[1:TT];
	logic [E_W-1:0] b_q_q  [1:TT];
	logic [E_W-1:0] b_v_q  [1:TT];
	tay_t           b_t_q  [1:TT];
	side_t          b_s_q  [1:TT];
	logic           b_vld_q[1:TT];
	tay_t           c_t_q  [1:TT];
	side_t          c_s_q  [1:TT];
	logic           c_vld_q[1:TT];

	// power stages
	logic [E_W-1:0]  ef;
	logic [ACC_W-1:0] diff;
	logic [E_W-1:0]  p_e_q  [0:PS-1];
	logic [IP_W-1:0] p_ip_q [0:PS-1];
	logic            p_deg_q[0:PS-1];
	logic            p_vld_q[0:PS-1];
	logic [E_W-1:0]  pi0;

	// product and output stages
	logic [E_W-1:0] mm_pi0_q, mm_pi1_q, mm_m0_q, mm_m1_q;
	logic           mm_deg_q, mm_vld_q;
	logic [E_W-1:0] pi1_w;
	logic [31:0]    v00, v01, v10, v11;
	logic           out_valid_q;
	logic [FRAC_BITS:0] p00_q, p01_q, p10_q, p11_q;
	logic           deg_q;

	function automatic logic [FRAC_BITS:0] to_out(input logic [31:0] v);
		logic [32:0] q;
		q = (33'(v) + RND) >> SH;
		return (q > 33'(ONE)) ? ONE : (FRAC_BITS+1)'(q);
	endfunction

	// the whole back pipe moves unless a result waits unread
	assign en  = ~out_valid_q | out_ready;
	assign pop = en & head_valid;

	// taylor series of exp(-r): multiply, reciprocal, correct and accumulate
	for (genvar k = 1; k <= TT; k++) begin : g_tay
		localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / k);
		logic [2*E_W-2:0] mul_w;
		logic [63:0]      qmul_w;
		logic [31:0]      prodk_w;
		logic [31:0]      rem_w;
		logic [E_W-1:0]   term_w;
		tay_t             nxt_w;
		if (k == 1) begin : g_first
			assign tin_w[k] = '{term: IONE, r: head.frac, pos: ACC_W'(IONE), neg: '0};
			assign sin_w[k] = '{r10: head.r10, s: head.s, ip: head.ip,
				flush: head.flush, deg: head.deg};
			assign vin_w[k] = head_valid;
		end else begin : g_next
			assign tin_w[k] = c_t_q[k-1];
			assign sin_w[k] = c_s_q[k-1];
			assign vin_w[k] = c_vld_q[k-1];
		end

		assign mul_w   = (2*E_W-1)'(tin_w[k].term) * (2*E_W-1)'(tin_w[k].r);
		assign qmul_w  = 64'(a_v_q[k]) * 64'(RECIP);
		assign prodk_w = 32'(b_q_q[k]) * 32'(k);
		assign rem_w   = 32'(b_v_q[k]) - prodk_w;
		assign term_w  = b_q_q[k] + E_W'(rem_w >= 32'(k));

		always_comb begin
			nxt_w      = b_t_q[k];
			nxt_w.term = term_w;
			if (k % 2 == 1)
				nxt_w.neg = b_t_q[k].neg + ACC_W'(term_w);
			else
				nxt_w.pos = b_t_q[k].pos + ACC_W'(term_w);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_vld_q[k] <= 1'b0;
				b_vld_q[k] <= 1'b0;
				c_vld_q[k] <= 1'b0;
			end else if (en) begin
				a_vld_q[k] <= vin_w[k];
				b_vld_q[k] <= a_vld_q[k];
				c_vld_q[k] <= b_vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_v_q[k] <= E_W'(mul_w >> IQ);
				a_t_q[k] <= tin_w[k];
				a_s_q[k] <= sin_w[k];
				b_q_q[k] <= E_W'(qmul_w >> 32);
				b_v_q[k] <= a_v_q[k];
				b_t_q[k] <= a_t_q[k];
				b_s_q[k] <= a_s_q[k];
				c_t_q[k] <= nxt_w;
				c_s_q[k] <= b_s_q[k];
			end
		end
	end

	// series sum clamped to [0, 1], flushed for large exponents
	always_comb begin
		diff = c_t_q[TT].pos - c_t_q[TT].neg;
		if (c_t_q[TT].neg > c_t_q[TT].pos || c_s_q[TT].flush)
			ef = '0;
		else if (diff > ACC_W'(IONE))
			ef = IONE;
		else
			ef = E_W'(diff);
	end

	// exp(-1)^ip by repeated truncating multiplies
	for (genvar j = 0; j < PS; j++) begin : g_pow
		logic [E_W-1:0]   e_in;
		logic [IP_W-1:0]  ip_in;
		logic             deg_in;
		logic             vld_in;
		logic [2*E_W-1:0] mul_w;
		if (j == 0) begin : g_first
			assign e_in   = ef;
			assign ip_in  = c_s_q[TT].ip;
			assign deg_in = c_s_q[TT].deg;
			assign vld_in = c_vld_q[TT];
		end else begin : g_next
			assign e_in   = p_e_q[j-1];
			assign ip_in  = p_ip_q[j-1];
			assign deg_in = p_deg_q[j-1];
			assign vld_in = p_vld_q[j-1];
		end
		assign mul_w = (2*E_W)'(e_in) * (2*E_W)'(E1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				p_vld_q[j] <= 1'b0;
			else if (en)
				p_vld_q[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_e_q[j]   <= (IP_W'(j) < ip_in) ? E_W'(mul_w >> IQ) : e_in;
				p_ip_q[j]  <= ip_in;
				p_deg_q[j] <= deg_in;
			end
		end
	end

	// stationary share, in step with the power chain
	tsm_div u_div (
		.clk (clk),
		.en  (en),
		.r10 (c_s_q[TT].r10),
		.s   (c_s_q[TT].s),
		.pi0 (pi0)
	);

	// pi1 as one minus pi0, then pi times e
	assign pi1_w = IONE - pi0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mm_vld_q <= 1'b0;
		else if (en)
			mm_vld_q <= p_vld_q[PS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mm_pi0_q <= pi0;
			mm_pi1_q <= pi1_w;
			mm_m0_q  <= E_W'(((2*E_W)'(pi0) * (2*E_W)'(p_e_q[PS-1])) >> IQ);
			mm_m1_q  <= E_W'(((2*E_W)'(pi1_w) * (2*E_W)'(p_e_q[PS-1])) >> IQ);
			mm_deg_q <= p_deg_q[PS-1];
		end
	end

	// matrix entries before rounding
	always_comb begin
		v00 = 32'(mm_pi0_q) + 32'(mm_m1_q);
		v01 = (mm_pi1_q >= mm_m1_q) ? 32'(mm_pi1_q - mm_m1_q) : '0;
		v10 = (mm_pi0_q >= mm_m0_q) ? 32'(mm_pi0_q - mm_m0_q) : '0;
		v11 = 32'(mm_pi1_q) + 32'(mm_m0_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= mm_vld_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mm_deg_q) begin
				p00_q <= ONE;
				p01_q <= '0;
				p10_q <= '0;
				p11_q <= ONE;
			end else begin
				p00_q <= to_out(v00);
				p01_q <= to_out(v01);
				p10_q <= to_out(v10);
				p11_q <= to_out(v11);
			end
			deg_q <= mm_deg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign p00 = p00_q;
	assign p01 = p01_q;
	assign p10 = p10_q;
	assign p11 = p11_q;
	assign deg = deg_q;

endmodule

// ===== sv/two_state_markov_transition_probs_top.sv =====
`timescale 1ns / 1ps
// Transition probabilities of a two-state continuous-time Markov chain.
// Slave stream: one transfer carries branch length t and the rates r01 and
// r10, all unsigned Q8.16 at the default FRAC_BITS of 16. Master stream:
// one transfer per input carries P00, P01, P10, P11 in Q1.FRAC_BITS on
// tdata and the degenerate flag on tuser (both rates zero, identity
// returned). Throughput: one item per cycle while the receiver keeps up.
// An item passes the queue, the 48-stage exp(-r) series (16 terms, three
// stages each), the 31-stage exp(-1) power chain run beside the 31-stage
// divider, one product stage and the output register.
// The front computes r01+r10 and the exponent and writes a 4-entry queue;
// the back pipeline drains it. While the receiver stalls the back pipeline
// holds, the queue fills and s_tready falls once it is full; no result is
// lost. Reset clears the queue and all valid bits; nothing else is kept
// between items.
module two_state_markov_transition_probs_top import tsm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// branch_length, rate_zero_to_one, rate_one_to_zero
	input  logic [3*IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// prob_stay_zero, prob_zero_to_one, prob_one_to_zero, prob_stay_one, zero fill
	output logic [((4*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);

	localparam int OUT_W = ((4 * (FRAC_BITS + 1) + 7) / 8) * 8;

	q_entry_t entry, head;
	logic     push, pop, q_full, q_empty;
	logic [FRAC_BITS:0] p00, p01, p10, p11;

	tsm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.entry    (entry)
	);

	tsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	tsm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (~q_empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.p00        (p00),
		.p01        (p01),
		.p10        (p10),
		.p11        (p11),
		.deg        (m_tuser)
	);

	// pack results, lowest field first
	assign m_tdata = OUT_W'({p11, p10, p01, p00});

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import tsm_pkg::*;

	localparam int FB      = 16;
	localparam int PW      = FB + 1;
	localparam int DW      = ((4 * PW + 7) / 8) * 8;
	localparam int LATENCY = 82;
	localparam longint QONE = 64'd1 << 30;

	typedef struct {
		logic [PW-1:0] p00;
		logic [PW-1:0] p01;
		logic [PW-1:0] p10;
		logic [PW-1:0] p11;
		logic          deg;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [3*IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic m_tuser;

	logic [3*IN_W-1:0] pending_items[$];
	matrix_t expected_matrices[$];
	int send_idle_pct = 16;
	int recv_idle_pct = 70;
	bit hold_send = 1'b0;
	bit errors = 1'b0;

	two_state_markov_transition_probs_top #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// truncated taylor series of exp(-r), Q.30
	function automatic longint unsigned series_exp(longint unsigned r);
		longint unsigned pos, neg, term;
		pos = QONE;
		neg = 0;
		term = QONE;
		if (r > QONE) r = QONE;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * r) >> 30) / k;
			if (k % 2) neg += term;
			else pos += term;
		end
		if (neg > pos) return 0;
		pos -= neg;
		return (pos > QONE) ? QONE : pos;
	endfunction

	// round Q.30 to Q.16 and cap at one
	function automatic logic [PW-1:0] round_prob(longint unsigned v);
		longint unsigned q;
		q = (v + (64'd1 << 13)) >> 14;
		return (q > (64'd1 << FB)) ? PW'(64'd1 << FB) : PW'(q);
	endfunction

	function automatic matrix_t transition_matrix(logic [3*IN_W-1:0] item);
		longint unsigned t, r01, r10, s, prod, x, ip, e, e1, pi0, pi1, m0, m1;
		matrix_t res;
		t = item[23:0];
		r01 = item[47:24];
		r10 = item[71:48];
		s = r01 + r10;
		if (s == 0) begin
			res.p00 = round_prob(QONE);
			res.p01 = '0;
			res.p10 = '0;
			res.p11 = round_prob(QONE);
			res.deg = 1'b1;
			return res;
		end
		prod = s * t;
		if ((prod >> 32) >= 32) begin
			e = 0;
		end else begin
			x = prod >> 2;
			ip = x >> 30;
			e = series_exp(x & (QONE - 1));
			e1 = series_exp(QONE);
			for (int i = 0; i < ip; i++) e = (e * e1) >> 30;
			if (e > QONE) e = QONE;
		end
		pi0 = (r10 << 30) / s;
		if (pi0 > QONE) pi0 = QONE;
		pi1 = QONE - pi0;
		m0 = (pi0 * e) >> 30;
		m1 = (pi1 * e) >> 30;
		res.p00 = round_prob(pi0 + m1);
		res.p01 = round_prob(pi1 >= m1 ? pi1 - m1 : 0);
		res.p10 = round_prob(pi0 >= m0 ? pi0 - m0 : 0);
		res.p11 = round_prob(pi1 + m0);
		res.deg = 1'b0;
		return res;
	endfunction

	function automatic logic [3*IN_W-1:0] pack_item(logic [23:0] t, logic [23:0] r01,
			logic [23:0] r10);
		return {r10, r01, t};
	endfunction

	// random field: mostly small rates and lengths, sometimes full range
	function automatic logic [23:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 255));
			2: return 24'($urandom_range(0, 24'h3FFFF));
			default: return 24'($urandom_range(0, 24'h1FFFF));
		endcase
	endfunction

	// driver: one transfer per accepted item, predicts on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_matrices.push_back(transition_matrix(s_tdata));
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_items.size() > 0 && !hold_send
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_items.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		matrix_t exp_m;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_matrices.size() == 0) begin
				$error("unexpected result transfer");
				errors = 1'b1;
			end else begin
				exp_m = expected_matrices.pop_front();
				if (m_tdata[PW-1:0] !== exp_m.p00) begin
					$error("prob_stay_zero exp %0d got %0d", exp_m.p00, m_tdata[PW-1:0]);
					errors = 1'b1;
				end
				if (m_tdata[2*PW-1:PW] !== exp_m.p01) begin
					$error("prob_zero_to_one exp %0d got %0d", exp_m.p01,
						m_tdata[2*PW-1:PW]);
					errors = 1'b1;
				end
				if (m_tdata[3*PW-1:2*PW] !== exp_m.p10) begin
					$error("prob_one_to_zero exp %0d got %0d", exp_m.p10,
						m_tdata[3*PW-1:2*PW]);
					errors = 1'b1;
				end
				if (m_tdata[4*PW-1:3*PW] !== exp_m.p11) begin
					$error("prob_stay_one exp %0d got %0d", exp_m.p11,
						m_tdata[4*PW-1:3*PW]);
					errors = 1'b1;
				end
				if (m_tuser !== exp_m.deg) begin
					$error("degenerate exp %0d got %0d", exp_m.deg, m_tuser);
					errors = 1'b1;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || s_tvalid || expected_matrices.size() > 0)
			@(posedge clk);
	endtask

	// stimulus and phase control
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// directed corners
		pending_items.push_back(pack_item(24'd0, 24'd0, 24'd0));
		pending_items.push_back(pack_item(24'hFFFFFF, 24'd0, 24'd0));
		pending_items.push_back(pack_item(24'd0, 24'd65536, 24'd65536));
		pending_items.push_back(pack_item(24'd0, 24'hFFFFFF, 24'hFFFFFF));
		pending_items.push_back(pack_item(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
		pending_items.push_back(pack_item(24'hFFFFFF, 24'd1, 24'd0));
		pending_items.push_back(pack_item(24'hFFFFFF, 24'd0, 24'd1));
		pending_items.push_back(pack_item(24'd1, 24'd1, 24'd1));
		pending_items.push_back(pack_item(24'd65536, 24'd65536, 24'd0));
		pending_items.push_back(pack_item(24'd65536, 24'd0, 24'd65536));
		pending_items.push_back(pack_item(24'd65536, 24'd32768, 24'd32768));
		// exponent just below and at the flush threshold
		pending_items.push_back(pack_item(24'd65536, 24'd2097151, 24'd0));
		pending_items.push_back(pack_item(24'd65536, 24'd1048576, 24'd1048576));
		pending_items.push_back(pack_item(24'd31 << 16, 24'd65536, 24'd0));
		pending_items.push_back(pack_item(24'h555555, 24'hAAAAAA, 24'h555555));
		pending_items.push_back(pack_item(24'hAAAAAA, 24'h555555, 24'hAAAAAA));
		pending_items.push_back(pack_item(24'd100, 24'hFFFFFF, 24'd3));
		// stimulus waits until everything has come back
		wait_drained();
		for (int i = 0; i < 550; i++) begin
			if (i == 200) begin
				hold_send = 1'b0;
				send_idle_pct = 70;
				recv_idle_pct = 16;
			end
			if (i == 400) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if ($urandom_range(0, 19) == 0)
				pending_items.push_back(pack_item(rand_field(), 24'd0, 24'd0));
			else
				pending_items.push_back(pack_item(rand_field(), rand_field(), rand_field()));
			if (i == 100) hold_send = 1'b0;
			while (pending_items.size() > 8) @(posedge clk);
		end
		hold_send = 1'b0;
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (!errors) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tsm_pkg.sv
sv/tsm_front.sv
sv/tsm_queue.sv
sv/tsm_div.sv
sv/tsm_back.sv
sv/two_state_markov_transition_probs_top.sv
dv/tb.sv
